FILE: rtl/qmc_pkg.sv
// Shared constants and command codes for the qubit measurement block.
`default_nettype none
package qmc_pkg;
	localparam int MAX_QUBITS = 10;
	localparam int AMP_BITS = 16;
	localparam int AMP_FRAC = AMP_BITS - 1;
	localparam int DEPTH = 1 << MAX_QUBITS;
	localparam int IDX_W = MAX_QUBITS;
	localparam int CNT_W = MAX_QUBITS + 1;
	localparam int NQ_W = 4;
	localparam int NCB_W = 6;
	localparam int ACC_W = 2 * AMP_FRAC + 1 + MAX_QUBITS + 1;
	localparam int RAD_W = 2 * ((ACC_W + 16 + 1) / 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int NUM_W = AMP_BITS + AMP_FRAC + 8;
	localparam int PROB_W = 17;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_MEASURE = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic CFG_NUM_QUBITS = 1'b0;
	localparam logic CFG_NUM_CBITS = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/qmc_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module qmc_sqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [qmc_pkg::RAD_W-1:0]  radicand,
	output logic                            done,
	output logic [qmc_pkg::ROOT_W-1:0]      root
);
	import qmc_pkg::*;

	logic [RAD_W-1:0]  val_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [$clog2(ROOT_W)-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W+1:0] rem_n;
	logic [ROOT_W+1:0] trial;

	assign rem_n = {rem_q[ROOT_W-1:0], val_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == ($clog2(ROOT_W))'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[RAD_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

FILE: rtl/qmc_div.sv
// Restoring divider for amplitude rescaling with saturation at 2^15.
`default_nettype none
module qmc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [qmc_pkg::NUM_W-1:0]   num,
	input  wire logic [qmc_pkg::ROOT_W-1:0]  den,
	output logic                             done,
	output logic [qmc_pkg::AMP_BITS-1:0]     quo
);
	import qmc_pkg::*;

	logic [ROOT_W-1:0]   rem_q;
	logic [AMP_FRAC-1:0] low_q;
	logic [AMP_BITS-1:0] quo_q;
	logic [3:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [ROOT_W:0]     rem_n;
	logic                sat;

	assign sat = ({1'b0, num} >= ({(ROOT_W + AMP_FRAC + 1)'(den)} << AMP_FRAC));
	assign rem_n = {rem_q, low_q[AMP_FRAC-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat;
				done_q <= sat;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 4'(AMP_FRAC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(num[NUM_W-1:AMP_FRAC]);
			low_q <= num[AMP_FRAC-1:0];
			quo_q <= sat ? (AMP_BITS'(1) << AMP_FRAC) : '0;
		end else if (busy_q) begin
			low_q <= {low_q[AMP_FRAC-2:0], 1'b0};
			if (rem_n >= {1'b0, den}) begin
				rem_q <= ROOT_W'(rem_n - {1'b0, den});
				quo_q <= {quo_q[AMP_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_n[ROOT_W-1:0];
				quo_q <= {quo_q[AMP_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

FILE: rtl/qubit_measure_collapse.sv
// Top level: state vector memory, command sequencer and measurement datapath.
// After reset the block clears the 1024-entry state memory and takes no transaction
// then; configuration writes are taken at any time. A write or a no-op is answered
// from idle, a read through the read state. A measure walks the 2^n entries once to
// sum the squared magnitudes (one multiplier pair), runs a square root, then walks
// them again: a discarded entry is zeroed and a kept entry is read and rescaled by
// two divisions, real part then imaginary part, on the shared divider. The root and
// the second walk are skipped when the kept half sums to zero.
`default_nettype none
module qubit_measure_collapse (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [qmc_pkg::NCB_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    cmd,
	input  wire logic [qmc_pkg::IDX_W-1:0]     entry_index,
	input  wire logic signed [15:0]            in_real,
	input  wire logic signed [15:0]            in_imag,
	input  wire logic [3:0]                    target_qubit,
	input  wire logic [4:0]                    target_cbit,
	input  wire logic [16:0]                   random_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               outcome,
	output logic [16:0]                        prob_one,
	output logic signed [15:0]                 out_real,
	output logic signed [15:0]                 out_imag,
	output logic [31:0]                        classical_bits
);
	import qmc_pkg::*;

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_SUM = 4'd3;
	localparam logic [3:0] S_DRAIN = 4'd4;
	localparam logic [3:0] S_EVAL = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_COL = 4'd7;
	localparam logic [3:0] S_CWAIT = 4'd8;
	localparam logic [3:0] S_DIVR = 4'd9;
	localparam logic [3:0] S_DIVI = 4'd10;

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                dcnt_q;
	logic [NQ_W-1:0]     num_qubits_q;
	logic [NCB_W-1:0]    num_cbits_q;
	logic [31:0]         creg_q;
	logic [2*AMP_BITS-1:0] mem [DEPTH];
	logic [2*AMP_BITS-1:0] rdata_q;
	logic                mem_we;
	logic [IDX_W-1:0]    waddr;
	logic [2*AMP_BITS-1:0] wdata;
	logic [IDX_W-1:0]    raddr;

	logic [IDX_W-1:0]    mask_q;
	logic [4:0]          cbit_q;
	logic [16:0]         rv_q;
	logic                meas_out_q;
	logic [ACC_W-1:0]    s0_q;
	logic [ACC_W-1:0]    s1_q;
	logic [ACC_W-1:0]    kept_q;
	logic                v_s1, sel_s1, v_s2, sel_s2;
	logic [2*AMP_BITS-1:0] sqr_s2, sqi_s2;
	logic signed [AMP_BITS-1:0] im_q;
	logic signed [AMP_BITS-1:0] res_re_q;

	logic                out_valid_q;
	logic                outcome_q;
	logic [16:0]         prob_q;
	logic [15:0]         ore_q, oim_q;

	logic [NQ_W-1:0]     nq;
	logic [CNT_W-1:0]    size_m1;
	logic [IDX_W-1:0]    idx;
	logic                accept;
	logic                cur_sel;
	logic                last;
	logic                load_out;
	logic [ACC_W-15:0]   prob_raw;
	logic [16:0]         prob_sat;
	logic                outc;
	logic [5:0]          nc;
	logic                sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]   root;
	logic [ROOT_W-1:0]   root_q;
	logic                div_start, div_done;
	logic [NUM_W-1:0]    div_num;
	logic [AMP_BITS-1:0] quo;
	logic signed [AMP_BITS-1:0] div_a_q;
	logic signed [AMP_BITS-1:0] div_src;
	logic [AMP_BITS-1:0] mag;
	logic signed [AMP_BITS-1:0] scaled;
	logic [IDX_W-1:0]    cur_idx;
	logic                tgt_ok;

	always_comb begin
		nq = num_qubits_q;
		if (nq == '0) nq = NQ_W'(1);
		if (nq > NQ_W'(MAX_QUBITS)) nq = NQ_W'(MAX_QUBITS);
	end
	assign size_m1 = (CNT_W'(1) << nq) - 1'b1;
	assign idx = entry_index & size_m1[IDX_W-1:0];
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign cur_idx = cnt_q[IDX_W-1:0];
	assign cur_sel = |(cur_idx & mask_q);
	assign last = (cnt_q == size_m1);
	assign tgt_ok = (target_qubit < nq);

	assign prob_raw = s1_q[ACC_W-1:2*AMP_FRAC-16];
	assign prob_sat = (prob_raw > (ACC_W-14)'(65536)) ? 17'd65536 : prob_raw[16:0];
	assign outc = ({1'b0, rv_q} <= {1'b0, prob_sat});
	assign nc = (num_cbits_q > 6'd32) ? 6'd32 : num_cbits_q;

	assign sqrt_start = (state_q == S_EVAL) && (outc ? (s1_q != '0) : (s0_q != '0));
	assign div_src = (state_q == S_CWAIT) ? $signed(rdata_q[2*AMP_BITS-1:AMP_BITS]) : im_q;
	assign div_start = (state_q == S_CWAIT) || ((state_q == S_DIVR) && div_done);
	assign mag = div_src[AMP_BITS-1] ? AMP_BITS'(-div_src) : AMP_BITS'(div_src);
	assign div_num = ({NUM_W'(mag)} << (AMP_FRAC + 8)) + NUM_W'(root_q >> 1);

	always_comb begin
		if (!div_a_q[AMP_BITS-1])
			scaled = quo[AMP_BITS-1] ? $signed({1'b0, {(AMP_BITS-1){1'b1}}}) : $signed(quo);
		else
			scaled = quo[AMP_BITS-1] ? $signed({1'b1, {(AMP_BITS-1){1'b0}}}) : $signed(-quo);
	end

	qmc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(RAD_W'(outc ? s1_q : s0_q) << 16),
		.done    (sqrt_done),
		.root    (root)
	);

	qmc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (root_q),
		.done  (div_done),
		.quo   (quo)
	);

	always_comb begin
		mem_we = 1'b0;
		waddr = cur_idx;
		wdata = '0;
		raddr = cur_idx;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				if (cnt_q == '0) wdata = {16'sh7fff, 16'sh0000};
			end
			S_IDLE: begin
				raddr = idx;
				waddr = idx;
				mem_we = accept && (cmd == CMD_WRITE);
				wdata = {in_real, in_imag};
			end
			S_COL: begin
				mem_we = (cur_sel != meas_out_q);
			end
			S_DIVI: begin
				mem_we = div_done;
				wdata = {res_re_q, scaled};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign load_out = (accept && !(cmd == CMD_READ) && !(cmd == CMD_MEASURE && tgt_ok))
		|| (state_q == S_RD)
		|| ((state_q == S_EVAL) && !sqrt_start)
		|| (((state_q == S_COL && cur_sel != meas_out_q)
			|| (state_q == S_DIVI && div_done)) && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q <= '0;
			dcnt_q <= 1'b0;
			num_qubits_q <= NQ_W'(1);
			num_cbits_q <= NCB_W'(1);
			creg_q <= '0;
			out_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_NUM_QUBITS) num_qubits_q <= cfg_data[NQ_W-1:0];
				else num_cbits_q <= cfg_data;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			v_s1 <= (state_q == S_SUM);
			v_s2 <= v_s1;
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (cmd == CMD_READ) state_q <= S_RD;
						else if (cmd == CMD_MEASURE && tgt_ok) state_q <= S_SUM;
					end
				end
				S_RD: state_q <= S_IDLE;
				S_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_DRAIN;
						dcnt_q <= 1'b0;
					end
				end
				S_DRAIN: begin
					dcnt_q <= 1'b1;
					if (dcnt_q) state_q <= S_EVAL;
				end
				S_EVAL: begin
					cnt_q <= '0;
					if ({1'b0, cbit_q} < nc) creg_q[5'(nc - 6'd1 - {1'b0, cbit_q})] <= outc;
					state_q <= sqrt_start ? S_SQRT : S_IDLE;
				end
				S_SQRT: if (sqrt_done) state_q <= S_COL;
				S_COL: begin
					if (cur_sel != meas_out_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (last) state_q <= S_IDLE;
					end else begin
						state_q <= S_CWAIT;
					end
				end
				S_CWAIT: state_q <= S_DIVR;
				S_DIVR: if (div_done) state_q <= S_DIVI;
				S_DIVI: begin
					if (div_done) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= last ? S_IDLE : S_COL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= cur_sel;
		sel_s2 <= sel_s1;
		sqr_s2 <= 32'($signed(rdata_q[31:16]) * $signed(rdata_q[31:16]));
		sqi_s2 <= 32'($signed(rdata_q[15:0]) * $signed(rdata_q[15:0]));
		if (accept) begin
			mask_q <= IDX_W'(1) << (nq - 1'b1 - target_qubit);
			cbit_q <= target_cbit;
			rv_q <= random_value;
			s0_q <= '0;
			s1_q <= '0;
		end else if (v_s2) begin
			if (sel_s2) s1_q <= s1_q + ACC_W'(sqr_s2) + ACC_W'(sqi_s2);
			else s0_q <= s0_q + ACC_W'(sqr_s2) + ACC_W'(sqi_s2);
		end
		if (state_q == S_EVAL) begin
			meas_out_q <= outc;
			kept_q <= outc ? s1_q : s0_q;
		end
		if (sqrt_done) root_q <= root;
		if (state_q == S_CWAIT) im_q <= $signed(rdata_q[15:0]);
		if (div_start) div_a_q <= div_src;
		if (state_q == S_DIVR && div_done) res_re_q <= scaled;
		if (accept) begin
			outcome_q <= 1'b0;
			prob_q <= '0;
			ore_q <= '0;
			oim_q <= '0;
		end else if (state_q == S_RD) begin
			ore_q <= rdata_q[31:16];
			oim_q <= rdata_q[15:0];
		end else if (state_q == S_EVAL) begin
			outcome_q <= outc;
			prob_q <= prob_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign outcome = outcome_q;
	assign prob_one = prob_q;
	assign out_real = $signed(ore_q);
	assign out_imag = $signed(oim_q);
	assign classical_bits = creg_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_div_kept: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> kept_q != '0) else $error("division with zero kept sum");
	a_sqrt_state: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == S_SQRT) else $error("root done outside root state");
endmodule
`default_nettype wire
